>>> hw/rtl/eaq_pkg.sv
package eaq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    // command codes (s_tuser)
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_POLL   = 2'd1;
    localparam logic [1:0] CMD_PRESET = 2'd2;

    // event kinds
    localparam logic [1:0] KIND_ROTATED  = 2'd0;
    localparam logic [1:0] KIND_PRESSED  = 2'd1;
    localparam logic [1:0] KIND_RELEASED = 2'd2;
    localparam logic [1:0] KIND_HELD     = 2'd3;

    // direction / motion sign codes
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_CW   = 2'd1;
    localparam logic [1:0] DIR_CCW  = 2'd2;
    localparam logic [1:0] DIR_BAD  = 2'd3;

    // rotation trend codes
    localparam logic [1:0] TREND_NONE = 2'd0;
    localparam logic [1:0] TREND_POS  = 2'd1;
    localparam logic [1:0] TREND_NEG  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ACCEL_ENABLE = 2'd0;
    localparam logic [1:0] CFG_IDLE_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_HOLD_THRESH  = 2'd2;

    localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd500;
    localparam logic [15:0] HOLD_THRESH_RST  = 16'd500;

    // acceleration tier bounds (ms) and half-step multipliers
    localparam logic [31:0] TIER_LIMIT = 32'd150;
    localparam logic [31:0] TIER_5X    = 32'd30;
    localparam logic [31:0] TIER_3X    = 32'd50;
    localparam logic [31:0] TIER_2X    = 32'd75;
    localparam logic [31:0] TIER_1P5X  = 32'd100;

    localparam logic [3:0] MULT_5X   = 4'd10;
    localparam logic [3:0] MULT_3X   = 4'd6;
    localparam logic [3:0] MULT_2X   = 4'd4;
    localparam logic [3:0] MULT_1P5X = 4'd3;
    localparam logic [3:0] MULT_1X   = 4'd2;

    // most events one sample can queue: rotation, press, release or held
    localparam int MAX_PUSH = 3;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [16:0] step;
        logic signed [15:0] pos;
        logic [31:0]        tm;
    } q_entry_t;

endpackage

>>> hw/rtl/encoder_accel_event_queue_unit.sv
// Rotary encoder event unit. Each input transfer carries one command (sample, poll or
// preset) and yields exactly one output transfer from a registered output. A new command
// is taken every cycle as long as the output register is empty or being drained in the
// same cycle, so the sustained rate is one item per clock; the output register is the only
// thing that sets it. Samples compute the accelerated step and push up to three events
// into a flop-based ring that overwrites its oldest entries when full; polls pop one event.
// Ring entries hold no reset value: only entries actually pushed are ever read back.
module encoder_accel_event_queue_unit #(
    parameter int QUEUE_DEPTH = eaq_pkg::QUEUE_DEPTH_DEF,
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1),
    localparam int OUT_BITS   = 88 + CNT_W,
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,

    input  logic             s_tvalid,
    output logic             s_tready,
    // position[15:0], motion_sign[17:16], now_ms[49:18], button_down[50],
    // button_latched[51], hold_ms[83:52], zero pad
    input  logic [87:0]      s_tdata,
    // command[1:0]
    input  logic [1:0]       s_tuser,

    output logic             m_tvalid,
    input  logic             m_tready,
    // event_step[16:0], event_position[32:17], event_time[64:33],
    // scaled_half_steps[85:65], direction[87:86], pending[87+CNT_W:88], zero pad
    output logic [OUT_W-1:0] m_tdata,
    // event_valid[0], event_kind[2:1]
    output logic [2:0]       m_tuser,

    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data
);
    import eaq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                 input logic [2:0] k);
        logic [PTR_W-1:0] r;
        r = p;
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < k)
                r = (r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(r + 1'b1);
        end
        return r;
    endfunction

    // configuration
    logic              accel_en_reg;
    logic [15:0]       idle_to_reg;
    logic [15:0]       hold_thr_reg;

    // tracking state
    logic signed [15:0] last_pos_reg,  last_pos_next;
    logic [1:0]         trend_reg,     trend_next;
    logic [31:0]        lmt_reg,       lmt_next;
    logic               bprev_reg,     bprev_next;
    logic [1:0]         dir_reg,       dir_next;
    logic signed [20:0] scaled_reg,    scaled_next;

    // ring
    q_entry_t           mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   cnt_reg,  cnt_next;

    // output register
    logic               m_tvalid_reg;
    logic               ev_valid_reg;
    q_entry_t           ev_reg;
    logic [CNT_W-1:0]   pend_reg;

    // input unpack
    logic [1:0]         cmd;
    logic signed [15:0] in_pos;
    logic [1:0]         in_msign;
    logic [31:0]        in_now;
    logic               in_down;
    logic               in_latched;
    logic [31:0]        in_hold;

    logic               acc;
    logic               do_sample;
    logic               poll_hit;
    logic               moved;
    logic signed [16:0] step;
    logic [31:0]        dt;
    logic               match;
    logic [3:0]         mult;
    logic signed [21:0] prod;
    logic               push_press;
    logic               push_rel;
    logic               push_held;
    q_entry_t           cand [4];
    logic [3:0]         cflag;
    q_entry_t           slot [4];
    logic [2:0]         push_n;
    logic [CNT_W:0]     total;
    logic [2:0]         drop;

    assign cmd        = s_tuser;
    assign in_pos     = s_tdata[15:0];
    assign in_msign   = s_tdata[17:16];
    assign in_now     = s_tdata[49:18];
    assign in_down    = s_tdata[50];
    assign in_latched = s_tdata[51];
    assign in_hold    = s_tdata[83:52];

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign acc       = s_tvalid && s_tready;
    assign do_sample = acc && (cmd == CMD_SAMPLE);
    assign poll_hit  = acc && (cmd == CMD_POLL) && (cnt_reg != '0);
    assign cfg_ready = 1'b1;

    assign moved = (in_pos != last_pos_reg);
    assign step  = $signed({in_pos[15], in_pos}) - $signed({last_pos_reg[15], last_pos_reg});
    assign dt    = (lmt_reg != '0) ? (in_now - lmt_reg) : '0;
    // step is nonzero whenever it is used, so the sign bit alone picks the direction
    assign match = (!step[16] && trend_reg != TREND_NEG) || (step[16] && trend_reg != TREND_POS);

    always_comb
    begin
        if (accel_en_reg && match && dt != '0 && dt < TIER_LIMIT)
        begin
            if (dt < TIER_5X)
                mult = MULT_5X;
            else if (dt < TIER_3X)
                mult = MULT_3X;
            else if (dt < TIER_2X)
                mult = MULT_2X;
            else if (dt < TIER_1P5X)
                mult = MULT_1P5X;
            else
                mult = MULT_1X;
        end
        else
        begin
            mult = MULT_1X;
        end
    end

    assign prod = step * $signed({1'b0, mult});

    // tracking state update
    always_comb
    begin
        last_pos_next = last_pos_reg;
        trend_next    = trend_reg;
        lmt_next      = lmt_reg;
        bprev_next    = bprev_reg;
        dir_next      = dir_reg;
        scaled_next   = scaled_reg;
        if (do_sample)
        begin
            if (moved)
            begin
                dir_next      = (in_msign == DIR_BAD) ? DIR_NONE : in_msign;
                trend_next    = accel_en_reg ? (step[16] ? TREND_NEG : TREND_POS) : TREND_NONE;
                lmt_next      = in_now;
                scaled_next   = prod[20:0];
                last_pos_next = in_pos;
            end
            else
            begin
                scaled_next = '0;
                dir_next    = DIR_NONE;
                if (lmt_reg != '0 && (in_now - lmt_reg) > {16'd0, idle_to_reg})
                begin
                    trend_next = TREND_NONE;
                    lmt_next   = '0;
                end
            end
            bprev_next = in_down;
        end
        else if (acc && cmd == CMD_PRESET)
        begin
            last_pos_next = in_pos;
            dir_next      = DIR_NONE;
            scaled_next   = '0;
            trend_next    = TREND_NONE;
            lmt_next      = '0;
        end
        // turning acceleration off drops the trend
        if (cfg_valid && cfg_ready && cfg_index == CFG_ACCEL_ENABLE && !cfg_data[0])
            trend_next = TREND_NONE;
    end

    assign push_press = in_latched || (!bprev_reg && in_down);
    assign push_rel   = bprev_reg && !in_down;
    assign push_held  = in_down && (in_hold > {16'd0, hold_thr_reg}) && !bprev_reg;

    // gather this sample's events in queue order
    always_comb
    begin
        cand[0] = '{kind: KIND_ROTATED, step: step, pos: in_pos, tm: in_now};
        cand[1] = '{kind: KIND_PRESSED, step: '0, pos: last_pos_next, tm: '0};
        cand[2] = '{kind: KIND_RELEASED, step: '0, pos: last_pos_next, tm: '0};
        cand[3] = '{kind: KIND_HELD, step: '0, pos: last_pos_next, tm: '0};
        cflag   = do_sample ? {push_held, push_rel, push_press, moved} : 4'b0000;
        for (int i = 0; i < 4; i++)
            slot[i] = '0;
        push_n = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (cflag[i])
            begin
                slot[push_n[1:0]] = cand[i];
                push_n = 3'(push_n + 1'b1);
            end
        end
    end

    // ring pointers; a full ring drops its oldest entries to make room
    always_comb
    begin
        total     = {1'b0, cnt_reg} + (CNT_W+1)'(push_n);
        drop      = (total > (CNT_W+1)'(QUEUE_DEPTH)) ?
                    3'(total - (CNT_W+1)'(QUEUE_DEPTH)) : 3'd0;
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        if (do_sample)
        begin
            tail_next = ptr_add(tail_reg, push_n);
            head_next = ptr_add(head_reg, drop);
            cnt_next  = CNT_W'(total - (CNT_W+1)'(drop));
        end
        else if (poll_hit)
        begin
            head_next = ptr_add(head_reg, 3'd1);
            cnt_next  = CNT_W'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_en_reg <= 1'b1;
            idle_to_reg  <= IDLE_TIMEOUT_RST;
            hold_thr_reg <= HOLD_THRESH_RST;
            last_pos_reg <= '0;
            trend_reg    <= TREND_NONE;
            lmt_reg      <= '0;
            bprev_reg    <= 1'b0;
            dir_reg      <= DIR_NONE;
            scaled_reg   <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            last_pos_reg <= last_pos_next;
            trend_reg    <= trend_next;
            lmt_reg      <= lmt_next;
            bprev_reg    <= bprev_next;
            dir_reg      <= dir_next;
            scaled_reg   <= scaled_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            cnt_reg      <= cnt_next;
            if (acc)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ACCEL_ENABLE: accel_en_reg <= cfg_data[0];
                    CFG_IDLE_TIMEOUT: idle_to_reg  <= cfg_data;
                    CFG_HOLD_THRESH:  hold_thr_reg <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    // ring storage and output payload
    always_ff @(posedge clk)
    begin
        if (do_sample)
        begin
            for (int j = 0; j < MAX_PUSH; j++)
            begin
                if (3'(j) < push_n)
                    mem[ptr_add(tail_reg, 3'(j))] <= slot[j];
            end
        end
        if (acc)
        begin
            if (poll_hit)
            begin
                ev_valid_reg <= 1'b1;
                ev_reg       <= mem[head_reg];
            end
            else
            begin
                ev_valid_reg <= 1'b0;
                ev_reg       <= '0;
            end
            pend_reg <= cnt_next;
        end
    end

    // scaled_reg and dir_reg already hold the post-item values, so they feed the output
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = {ev_reg.kind, ev_valid_reg};
    assign m_tdata  = OUT_W'({pend_reg, dir_reg, scaled_reg, ev_reg.tm, ev_reg.pos, ev_reg.step});

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("ring count above depth");

    a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0 || cnt_reg == CNT_W'(QUEUE_DEPTH)) |-> (head_reg == tail_reg))
        else $error("ring pointers disagree with count");

    a_trend_accel: assert property (@(posedge clk) disable iff (!rst_n)
        (trend_reg != TREND_NONE) |-> accel_en_reg)
        else $error("rotation trend kept with acceleration off");

    a_poll_pops: assert property (@(posedge clk) disable iff (!rst_n)
        poll_hit |=> (cnt_reg == CNT_W'($past(cnt_reg) - 1'b1)) && ev_valid_reg)
        else $error("poll did not pop one event");

endmodule
